@@ hdl/gffd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffd_pkg
// shared types and constants for the gliding fractional feedback delay
// ----------------------------------------------------------------------------
package gffd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int GAIN_ONE  = 32768;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;
    localparam int CFG_AW    = 3;

    // register index taken from the word address
    localparam logic REG_FEEDBACK_GAIN = 1'b0;

    typedef enum logic {
        OP_SAMPLE    = 1'b0,
        OP_SET_DELAY = 1'b1
    } op_t;

    // datapath commands, one step each
    typedef struct packed {
        logic load_in;
        logic glide_add;
        logic glide_fix;
        logic addr_offs;
        logic addr_wrap;
        logic rd_a;
        logic rd_b;
        logic mul_b;
        logic sum;
        logic fb;
        logic wr;
        logic sd_check;
        logic sd_decide;
        logic sd_clamp;
        logic div_step;
        logic div_end;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sd_finish;
        logic sd_clamp;
        logic out_free;
    } stat_t;

endpackage

@@ hdl/gffd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffd_ctrl
// sequencer that steps the datapath through one item at a time
// ----------------------------------------------------------------------------
module gffd_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            op_sel,
    input  gffd_pkg::stat_t st,
    output logic            s_tready,
    output gffd_pkg::cmd_t  cmd
);
    import gffd_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE      = 16'b0000_0000_0000_0001,
        ST_GL_ADD    = 16'b0000_0000_0000_0010,
        ST_GL_FIX    = 16'b0000_0000_0000_0100,
        ST_OFFS      = 16'b0000_0000_0000_1000,
        ST_ADDR      = 16'b0000_0000_0001_0000,
        ST_RD_A      = 16'b0000_0000_0010_0000,
        ST_RD_B      = 16'b0000_0000_0100_0000,
        ST_MUL_B     = 16'b0000_0000_1000_0000,
        ST_SUM       = 16'b0000_0001_0000_0000,
        ST_FB        = 16'b0000_0010_0000_0000,
        ST_WRITE     = 16'b0000_0100_0000_0000,
        ST_SD_CHECK  = 16'b0000_1000_0000_0000,
        ST_SD_DECIDE = 16'b0001_0000_0000_0000,
        ST_SD_CLAMP  = 16'b0010_0000_0000_0000,
        ST_DIV       = 16'b0100_0000_0000_0000,
        ST_DONE      = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   div_end_reg;
    logic   div_end_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        div_end_next = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (op_t'(op_sel) == OP_SAMPLE) ? ST_GL_ADD : ST_SD_CHECK;
                end
            end
            ST_GL_ADD:
            begin
                cmd.glide_add = 1'b1;
                state_next    = ST_GL_FIX;
            end
            ST_GL_FIX:
            begin
                cmd.glide_fix = 1'b1;
                state_next    = ST_OFFS;
            end
            ST_OFFS:
            begin
                cmd.addr_offs = 1'b1;
                state_next    = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr_wrap = 1'b1;
                state_next    = ST_RD_A;
            end
            ST_RD_A:
            begin
                cmd.rd_a   = 1'b1;
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                cmd.rd_b   = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_FB;
            end
            ST_FB:
            begin
                cmd.fb     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_DONE;
            end
            ST_SD_CHECK:
            begin
                cmd.sd_check = 1'b1;
                state_next   = ST_SD_DECIDE;
            end
            ST_SD_DECIDE:
            begin
                cmd.sd_decide = 1'b1;
                state_next    = st.sd_finish ? ST_DONE : ST_SD_CLAMP;
            end
            ST_SD_CLAMP:
            begin
                cmd.sd_clamp = 1'b1;
                state_next   = st.sd_clamp ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                // multiply first, then the step is taken from the product
                if (div_end_reg)
                begin
                    cmd.div_end = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    div_end_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_end_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_end_reg <= div_end_next;
        end
    end

endmodule

@@ hdl/gffd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffd_dp
// delay store, glide and step scaling logic, interpolation and feedback math
// ----------------------------------------------------------------------------
module gffd_dp
#(
    parameter int BUFFER_DEPTH  = 65536,
    parameter int GLIDE_SAMPLES = 11025,
    parameter int MAX_STEP      = 3
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  gffd_pkg::cmd_t                      cmd,
    input  logic [gffd_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic [gffd_pkg::GAIN_W-1:0]         gain,
    input  logic                                m_tready,
    output gffd_pkg::stat_t                     st,
    output logic                                m_tvalid,
    output logic [gffd_pkg::M_TDATA_W-1:0]      m_tdata
);
    import gffd_pkg::*;

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int DW   = $clog2(BUFFER_DEPTH + 1);
    localparam int CW   = DW + FRAC_W;
    localparam int SCW  = ((CW > DELAY_W + FRAC_W) ? CW : DELAY_W + FRAC_W) + 2;
    localparam int LIM  = MAX_STEP * (1 << FRAC_W);
    localparam int LW   = $clog2(LIM + 1);
    localparam int SW   = LW + 1;
    localparam int QW   = LW;

    localparam logic [63:0]   LIMG        = 64'(LIM) * 64'(GLIDE_SAMPLES);
    localparam logic [CW-1:0] MAX_DELAY_Q = CW'(BUFFER_DEPTH) << FRAC_W;

    // reciprocal of the glide length, exact for every distance below LIMG
    localparam int            NW      = $clog2(LIMG);
    localparam int            KSH     = $clog2(LIMG * 64'(GLIDE_SAMPLES));
    localparam logic [63:0]   RECIP   = ((64'd1 << KSH) + 64'(GLIDE_SAMPLES - 1))
                                      / 64'(GLIDE_SAMPLES);
    localparam int            MW      = $clog2(RECIP + 64'd1);
    localparam int            PW      = NW + MW;
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

    // item fields
    op_t                        op_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [DELAY_W-1:0]         d_reg;
    logic                       gl_reg;

    // delay state
    logic [CW-1:0]              current_reg;
    logic [DW-1:0]              target_reg;
    logic signed [SW-1:0]       step_reg;
    logic                       gliding_reg;
    logic [AW-1:0]              wp_reg;
    logic                       wrapped_reg;

    // sample path
    logic signed [SCW-1:0]      sum_reg;
    logic [DW-1:0]              off_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [AW-1:0]              ia_reg;
    logic [AW-1:0]              ib_reg;
    logic                       a_ok_reg;
    logic                       b_ok_reg;
    logic [SAMPLE_W-1:0]        rdata_reg;
    logic signed [33:0]         pa_reg;
    logic signed [32:0]         pb_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [32:0]         m_reg;

    // set-delay path
    logic signed [SCW-1:0]      diff_reg;
    logic                       bad_reg;
    logic [CW-1:0]              abs_reg;
    logic                       neg_reg;
    logic                       rej_reg;
    logic [PW-1:0]              prod_reg;

    logic                       out_valid_reg;
    logic [M_TDATA_W-1:0]       out_data_reg;

    logic [SAMPLE_W-1:0]        mem [BUFFER_DEPTH];

    // combinational terms
    logic signed [SCW-1:0]      cur_s;
    logic signed [SCW-1:0]      tq_s;
    logic signed [SCW-1:0]      step_s;
    logic signed [SCW-1:0]      step_mag;
    logic signed [SCW-1:0]      left_s;
    logic signed [SCW-1:0]      left_mag;
    logic                       stop;
    logic signed [SCW-1:0]      nv_s;
    logic signed [SCW-1:0]      max_s;
    logic [CW-1:0]              nv_clamped;
    logic [DW:0]                off_w;
    logic [AW+1:0]              pos_w;
    logic [AW+1:0]              ia_w;
    logic signed [SAMPLE_W-1:0] a_s;
    logic signed [SAMPLE_W-1:0] b_s;
    logic [FRAC_W:0]            omf;
    logic signed [34:0]         tot;
    logic signed [33:0]         fbv;
    logic signed [18:0]         fbs;
    logic signed [19:0]         w_full;
    logic [SAMPLE_W-1:0]        w_sat;
    logic signed [SCW-1:0]      tqd_s;
    logic [CW-1:0]              d_q16;
    logic [AW-1:0]              rd_addr;
    logic [NW-1:0]              abs_n;
    logic [QW-1:0]              q_div;
    logic [QW-1:0]              q_mag;

    assign cur_s    = signed'(SCW'(current_reg));
    assign tq_s     = signed'(SCW'({target_reg, {FRAC_W{1'b0}}}));
    assign step_s   = SCW'(step_reg);
    assign step_mag = (step_s < 0) ? -step_s : step_s;
    assign left_s   = tq_s - sum_reg;
    assign left_mag = (left_s < 0) ? -left_s : left_s;
    assign stop     = (left_mag < step_mag);
    assign nv_s     = stop ? tq_s : sum_reg;
    assign max_s    = signed'(SCW'(MAX_DELAY_Q));

    always_comb
    begin
        if (nv_s < 0)
        begin
            nv_clamped = '0;
        end
        else if (nv_s > max_s)
        begin
            nv_clamped = MAX_DELAY_Q;
        end
        else
        begin
            nv_clamped = nv_s[CW-1:0];
        end
    end

    // whole-sample distance behind the write pointer, fraction borrows one
    assign off_w = (DW+1)'(BUFFER_DEPTH) - {1'b0, current_reg[CW-1:FRAC_W]}
                 - (DW+1)'(|current_reg[FRAC_W-1:0]);
    assign pos_w = (AW+2)'(wp_reg) + (AW+2)'(off_reg);
    assign ia_w  = (pos_w >= (AW+2)'(BUFFER_DEPTH)) ? pos_w - (AW+2)'(BUFFER_DEPTH) : pos_w;

    // never-written entries read as zero
    assign a_s = a_ok_reg ? signed'(rdata_reg) : '0;
    assign b_s = b_ok_reg ? signed'(rdata_reg) : '0;
    assign omf = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(frac_reg);

    assign tot    = 35'(pa_reg) + 35'(pb_reg) + 35'sd32768;
    assign fbv    = 34'(m_reg) + 34'sd16384;
    assign fbs    = signed'(fbv[33:15]);
    assign w_full = 20'(fbs) + 20'(x_reg);

    always_comb
    begin
        if (w_full > 20'sd32767)
        begin
            w_sat = 16'h7fff;
        end
        else if (w_full < -20'sd32768)
        begin
            w_sat = 16'h8000;
        end
        else
        begin
            w_sat = w_full[SAMPLE_W-1:0];
        end
    end

    assign tqd_s   = signed'(SCW'({d_reg, {FRAC_W{1'b0}}}));
    assign d_q16   = {DW'(d_reg), {FRAC_W{1'b0}}};
    assign rd_addr = cmd.rd_b ? ib_reg : ia_reg;

    // quotient by the glide length: multiply by the reciprocal, then shift
    assign abs_n = NW'(abs_reg);
    assign q_div = QW'(prod_reg >> KSH);
    assign q_mag = (q_div == '0) ? QW'(1) : q_div;

    assign st.sd_finish = (diff_reg == '0) || bad_reg || !gl_reg;
    assign st.sd_clamp  = (64'(abs_reg) >= LIMG);
    assign st.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // sample store
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wp_reg] <= w_sat;
        end
        if (cmd.rd_a || cmd.rd_b)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // delay and pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg <= '0;
            target_reg  <= '0;
            step_reg    <= '0;
            gliding_reg <= 1'b0;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            if (cmd.glide_fix && gliding_reg)
            begin
                current_reg <= nv_clamped;
                if (stop)
                begin
                    gliding_reg <= 1'b0;
                end
            end
            if (cmd.wr)
            begin
                if (wp_reg == AW'(BUFFER_DEPTH - 1))
                begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + AW'(1);
                end
            end
            if (cmd.sd_decide && (diff_reg != '0) && !bad_reg && !gl_reg)
            begin
                current_reg <= d_q16;
                gliding_reg <= 1'b0;
            end
            if (cmd.sd_clamp && st.sd_clamp)
            begin
                step_reg    <= neg_reg ? -SW'(LIM) : SW'(LIM);
                target_reg  <= DW'(d_reg);
                gliding_reg <= 1'b1;
            end
            if (cmd.div_end)
            begin
                step_reg    <= neg_reg ? -signed'(SW'(q_mag)) : signed'(SW'(q_mag));
                target_reg  <= DW'(d_reg);
                gliding_reg <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= op_t'(s_tuser);
            x_reg  <= signed'(s_tdata[15:0]);
            d_reg  <= s_tdata[32:16];
            gl_reg <= s_tdata[33];
        end
        if (cmd.glide_add)
        begin
            sum_reg <= cur_s + step_s;
        end
        if (cmd.addr_offs)
        begin
            off_reg  <= off_w[DW-1:0];
            frac_reg <= ~current_reg[FRAC_W-1:0] + FRAC_W'(1);
        end
        if (cmd.addr_wrap)
        begin
            ia_reg <= ia_w[AW-1:0];
        end
        if (cmd.rd_a)
        begin
            a_ok_reg <= wrapped_reg || (ia_reg < wp_reg);
            ib_reg   <= (ia_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : ia_reg + AW'(1);
        end
        if (cmd.rd_b)
        begin
            b_ok_reg <= wrapped_reg || (ib_reg < wp_reg);
            pa_reg   <= 34'(a_s) * 34'(signed'({1'b0, omf}));
        end
        if (cmd.mul_b)
        begin
            pb_reg <= 33'(b_s) * 33'(signed'({1'b0, frac_reg}));
        end
        if (cmd.sum)
        begin
            y_reg <= signed'(tot[31:16]);
        end
        if (cmd.fb)
        begin
            m_reg <= 33'(y_reg) * 33'(signed'({1'b0, gain}));
        end
        if (cmd.sd_check)
        begin
            diff_reg <= tqd_s - cur_s;
            bad_reg  <= (d_reg == '0) || (32'(d_reg) > 32'(BUFFER_DEPTH));
        end
        if (cmd.sd_decide)
        begin
            rej_reg <= (diff_reg != '0) && bad_reg;
            neg_reg <= (diff_reg < 0);
            abs_reg <= (diff_reg < 0) ? CW'(-diff_reg) : CW'(diff_reg);
        end
        if (cmd.div_step)
        begin
            prod_reg <= PW'(abs_n) * PW'(RECIP_M);
        end
        if (cmd.out_load)
        begin
            if (op_reg == OP_SAMPLE)
            begin
                out_data_reg <= {8'h00, y_reg};
            end
            else
            begin
                out_data_reg <= {7'h00, rej_reg, 16'h0000};
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ hdl/gliding_fractional_feedback_delay.sv @@
`timescale 1ns / 1ps
// sequence: a sample beat steps through glide, address, read, multiply, sum,
// feedback and write states; a set-delay beat through check and decide (jump,
// no change or rejection), then clamp for a clamped glide step, then reciprocal
// multiply and shift for a scaled step; one beat in flight, with two reads on
// the single store port, three multiplies and the glide update in one sequencer
// reset: async active low clears control, pointer, delay and gain; the store is
// not swept, entries not yet written since reset read as zero via the wrap flag
// ----------------------------------------------------------------------------
// gliding_fractional_feedback_delay
// circular feedback delay with interpolated fractional tap and delay glide
// ----------------------------------------------------------------------------
module gliding_fractional_feedback_delay
#(
    parameter int BUFFER_DEPTH  = 65536,
    parameter int GLIDE_SAMPLES = 11025,
    parameter int MAX_STEP      = 3
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gffd_pkg::CFG_AW-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_in[15:0], new_delay[32:16], glide[33], zero pad[39:34]
    input  logic [gffd_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation[0]
    input  logic                                s_tuser,
    // result beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sample_out[15:0], rejected[16], zero pad[23:17]
    output logic [gffd_pkg::M_TDATA_W-1:0]      m_tdata
);
    import gffd_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] gain_next;
    logic              cfg_wr;
    cmd_t              cmd;
    stat_t             st;

    // register write completes in the access phase; pready is tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FEEDBACK_GAIN);

    // gains above unity are held at unity
    assign gain_next = (pwdata[GAIN_W-1:0] > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE)
                                                               : pwdata[GAIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
        end
        else if (cfg_wr)
        begin
            gain_reg <= gain_next;
        end
    end

    // readback of the stored gain, other words read zero
    assign prdata = (paddr[2] == REG_FEEDBACK_GAIN) ? {16'h0000, gain_reg} : 32'h0000_0000;

    // sequencer: glide, address, read, multiply, sum, write, set-delay steps
    gffd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op_sel   (s_tuser),
        .st       (st),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // datapath: store, delay state, step scaling and result register
    gffd_dp
    #(
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .GLIDE_SAMPLES (GLIDE_SAMPLES),
        .MAX_STEP      (MAX_STEP)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .gain     (gain_reg),
        .m_tready (m_tready),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
